// ===== src/rowf_pkg.sv =====
// Package for the rank-order window filter: shared widths, register indexes,
// filter mode codes and the item descriptor passed between pipeline stages.
// No dependencies.
package rowf_pkg;

   localparam int PIXEL_BITS      = 8;
   localparam int POS_BITS        = 13;
   localparam int ITEM_BITS       = 23;
   localparam int TOTAL_BITS      = 27;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int MODE_BITS       = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_MODE  = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_MAX    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MEDIAN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MIN    = 2'd2;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [HEIGHT_REG_BITS-1:0] MAX_HEIGHT   = 13'd4096;

   // Per-item descriptor: whether the item yields a result, and where that result sits.
   typedef struct packed {
      logic                has_out;
      logic                last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } item_info_type;

endpackage

// ===== src/rowf_line_store.sv =====
// Line store of the rank-order filter: one word per image column holding the
// previous WINDOW-1 rows, read-modify-write with write-to-read forwarding.
// Depends on rowf_pkg.
module rowf_line_store #(
   parameter int WINDOW    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]             rd_addr,
   input  logic                                     wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]             wr_addr,
   input  logic [rowf_pkg::PIXEL_BITS-1:0]          pixel,
   output logic [WINDOW*rowf_pkg::PIXEL_BITS-1:0]   col_vec
);

   localparam int PB = rowf_pkg::PIXEL_BITS;
   localparam int LW = (WINDOW - 1) * PB;

   logic [LW-1:0] mem [MAX_WIDTH];
   logic [LW-1:0] rd_ff;
   logic [LW-1:0] fwd_data_ff;
   logic          fwd_ff;
   logic [LW-1:0] line_word;
   logic [LW-1:0] wr_data;

   // Newest row sits in the lowest slot; the oldest row drops out on write-back.
   always_comb begin
      line_word = fwd_ff ? fwd_data_ff : rd_ff;
      wr_data   = {line_word[LW-PB-1:0], pixel};
      col_vec   = {line_word, pixel};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         // Same column written on this edge: take the new word instead of the stale read.
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

endmodule

// ===== src/rowf_window.sv =====
// Window register array of the rank-order filter: shifts in one column per
// item and masks taps outside the frame to zero. Depends on rowf_pkg.
module rowf_window #(
   parameter int WINDOW = 3
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          shift_en,
   input  logic                                          load_en,
   input  logic [WINDOW*rowf_pkg::PIXEL_BITS-1:0]        col_vec,
   input  rowf_pkg::item_info_type                       info,
   input  logic [rowf_pkg::POS_BITS-1:0]                 w_eff,
   input  logic [rowf_pkg::POS_BITS-1:0]                 h_eff,
   output logic                                          ready,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [WINDOW*WINDOW*rowf_pkg::PIXEL_BITS-1:0] out_taps,
   output logic                                          out_last
);

   localparam int PB   = rowf_pkg::PIXEL_BITS;
   localparam int PAD  = (WINDOW - 1) / 2;
   localparam int VB   = WINDOW * PB;
   localparam int TAPS = WINDOW * WINDOW;
   localparam int RB   = rowf_pkg::POS_BITS + 1;

   logic [VB-1:0]      win_ff [WINDOW];
   logic [VB-1:0]      win_in [WINDOW];
   logic [WINDOW-1:0]  row_ok;
   logic [WINDOW-1:0]  col_ok;
   logic [RB-1:0]      rp;
   logic [RB-1:0]      cp;
   logic [TAPS*PB-1:0] taps_in;
   logic [TAPS*PB-1:0] taps_ff;
   logic               last_ff;
   logic               v_ff;

   always_comb begin
      win_in[0] = col_vec;
      for (int j = 1; j < WINDOW; j++) begin
         win_in[j] = win_ff[j-1];
      end
      rp = {1'b0, info.row} + RB'(PAD);
      cp = {1'b0, info.col} + RB'(PAD);
      // Row e of a column vector is PAD-e rows below the center; column j is PAD-j right.
      for (int e = 0; e < WINDOW; e++) begin
         row_ok[e] = (rp >= RB'(e)) && ((rp - RB'(e)) < {1'b0, h_eff});
      end
      for (int j = 0; j < WINDOW; j++) begin
         col_ok[j] = (cp >= RB'(j)) && ((cp - RB'(j)) < {1'b0, w_eff});
      end
      for (int j = 0; j < WINDOW; j++) begin
         for (int e = 0; e < WINDOW; e++) begin
            taps_in[(j*WINDOW+e)*PB +: PB] =
               (row_ok[e] && col_ok[j]) ? win_in[j][e*PB +: PB] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int j = 0; j < WINDOW; j++) begin
            win_ff[j] <= win_in[j];
         end
      end
      if (load_en) begin
         taps_ff <= taps_in;
         last_ff <= info.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (load_en) begin
         v_ff <= 1'b1;
      end else if (out_ready) begin
         v_ff <= 1'b0;
      end
   end

   assign ready     = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_taps  = taps_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/rowf_rank_select.sv =====
// Rank selector of the rank-order filter: pairwise compare, rank count and
// pick of the maximum, median or minimum over three registered stages.
// Depends on rowf_pkg.
module rowf_rank_select #(
   parameter int WINDOW = 3
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [rowf_pkg::MODE_BITS-1:0]                mode,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [WINDOW*WINDOW*rowf_pkg::PIXEL_BITS-1:0] in_taps,
   input  logic                                          in_last,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [rowf_pkg::PIXEL_BITS-1:0]               out_pixel,
   output logic                                          out_last
);

   localparam int PB   = rowf_pkg::PIXEL_BITS;
   localparam int TAPS = WINDOW * WINDOW;
   localparam int RB   = $clog2(TAPS);

   logic [PB-1:0]   val_in   [TAPS];
   logic [TAPS-1:0] beat_in  [TAPS];
   logic [PB-1:0]   bval_ff  [TAPS];
   logic [TAPS-1:0] beat_ff  [TAPS];
   logic            blast_ff;
   logic            bv_ff;
   logic [PB-1:0]   kval_ff  [TAPS];
   logic [RB-1:0]   rank_in  [TAPS];
   logic [RB-1:0]   rank_ff  [TAPS];
   logic            klast_ff;
   logic            kv_ff;
   logic [PB-1:0]   pick_in;
   logic [PB-1:0]   pix_ff;
   logic            olast_ff;
   logic            ov_ff;
   logic [RB-1:0]   target;
   logic            pass;
   logic            o_free;
   logic            o_load;
   logic            k_free;
   logic            k_load;
   logic            b_free;
   logic            b_load;

   // Ties break by tap index, so ranks form a permutation of 0..TAPS-1.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         val_in[i] = in_taps[i*PB +: PB];
      end
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            beat_in[i][j] = (val_in[j] < val_in[i]) || ((val_in[j] == val_in[i]) && (j < i));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         rank_in[i] = RB'($countones(beat_ff[i]));
      end
   end

   always_comb begin
      target = '0;
      pass   = 1'b1;
      unique case (mode)
         rowf_pkg::MODE_MAX:    target = RB'(TAPS - 1);
         rowf_pkg::MODE_MEDIAN: target = RB'((TAPS - 1) / 2);
         rowf_pkg::MODE_MIN:    target = '0;
         default:               pass   = 1'b0;
      endcase
      pick_in = '0;
      for (int i = 0; i < TAPS; i++) begin
         if (rank_ff[i] == target) begin
            pick_in = pick_in | kval_ff[i];
         end
      end
      if (!pass) begin
         pick_in = '0;
      end
   end

   assign o_free   = !ov_ff || out_ready;
   assign o_load   = kv_ff && o_free;
   assign k_free   = !kv_ff || o_load;
   assign k_load   = bv_ff && k_free;
   assign b_free   = !bv_ff || k_load;
   assign b_load   = in_valid && b_free;
   assign in_ready = b_free;

   always_ff @(posedge clock) begin
      if (b_load) begin
         for (int i = 0; i < TAPS; i++) begin
            bval_ff[i] <= val_in[i];
            beat_ff[i] <= beat_in[i];
         end
         blast_ff <= in_last;
      end
      if (k_load) begin
         for (int i = 0; i < TAPS; i++) begin
            kval_ff[i] <= bval_ff[i];
            rank_ff[i] <= rank_in[i];
         end
         klast_ff <= blast_ff;
      end
      if (o_load) begin
         pix_ff   <= pick_in;
         olast_ff <= klast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
         kv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (b_load) begin
            bv_ff <= 1'b1;
         end else if (k_load) begin
            bv_ff <= 1'b0;
         end
         if (k_load) begin
            kv_ff <= 1'b1;
         end else if (o_load) begin
            kv_ff <= 1'b0;
         end
         if (o_load) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_pixel = pix_ff;
   assign out_last  = olast_ff;

endmodule

// ===== src/rank_order_window_filter_unit.sv =====
// Top level of the rank-order window filter (maximum, median or minimum).
// Depends on rowf_pkg, rowf_line_store, rowf_window and rowf_rank_select.
//
// Feed an 8-bit grayscale frame in raster order, one pixel per req transfer.
// For each frame position the block returns the maximum, median or minimum
// of the WINDOW x WINDOW neighborhood centered there; neighbors outside the
// frame count as zero. A result belongs to the item PAD rows plus PAD pixels
// later (PAD = (WINDOW-1)/2), so after the last pixel of a frame send
// PAD*image_width + PAD filler transfers whose data is ignored; the final
// result of the frame carries rsp_tlast. The block accepts one pixel every
// clock cycle while rsp_tready is high; that rate is set by the line store,
// which does one column read and one column write-back per cycle. After the
// transfer that completes its window, a result passes the line read, window
// and mask, compare, rank count and pick registers and waits in the output
// register while rsp_tready is low. The frame length is recomputed through
// the lag, product and total registers, so the settle register holds
// req_tready low after each csr write and after reset. The line store holds
// no reset and needs no clearing pass: only columns already written in the
// current frame are used. Write the csr registers only between frames, when
// no result is outstanding; widths of zero or above MAX_WIDTH and heights of
// zero or above 4096 are clamped, and filter mode 3 returns zero.
module rank_order_window_filter_unit #(
   parameter int WINDOW    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rowf_pkg::PIXEL_BITS-1:0]       req_tdata,   // [7:0] pixel_in
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rowf_pkg::PIXEL_BITS-1:0]       rsp_tdata,   // [7:0] pixel_out
   output logic                                  rsp_tlast,   // last_of_frame
   input  logic                                  csr_we,
   input  logic [rowf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rowf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int PB  = rowf_pkg::PIXEL_BITS;
   localparam int PAD = (WINDOW - 1) / 2;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int EW  = (WW > rowf_pkg::WIDTH_REG_BITS) ? WW : rowf_pkg::WIDTH_REG_BITS;
   localparam int TB  = rowf_pkg::TOTAL_BITS;
   localparam int NB  = rowf_pkg::ITEM_BITS;
   localparam int HB  = rowf_pkg::HEIGHT_REG_BITS;
   localparam int PSB = rowf_pkg::POS_BITS;

   // Configuration registers
   logic [rowf_pkg::WIDTH_REG_BITS-1:0] width_ff;
   logic [HB-1:0]                       height_ff;
   logic [rowf_pkg::MODE_BITS-1:0]      mode_ff;

   // Derived frame geometry
   logic [EW-1:0] w_raw;
   logic [WW-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic [TB-1:0] lag_in;
   logic [TB-1:0] lag_ff;
   logic [TB-1:0] prod_ff;
   logic [TB-1:0] total_ff;
   logic [1:0]    settle_ff;

   // Input and output position counters
   logic [NB-1:0]  n_ff;
   logic [CW-1:0]  col_ff;
   logic [PSB-1:0] orow_ff;
   logic [CW-1:0]  ocol_ff;
   logic [TB-1:0]  n_next;
   logic           frame_end;
   logic           has_out;
   logic           col_wrap;
   logic           ocol_wrap;

   // Line-read stage
   logic                     s1_v_ff;
   logic [PB-1:0]            s1_pixel_ff;
   logic [CW-1:0]            s1_col_ff;
   rowf_pkg::item_info_type  s1_info_ff;
   rowf_pkg::item_info_type  s1_info_in;
   logic                     s1_fire;
   logic                     accept;

   logic [WINDOW*PB-1:0]        col_vec;
   logic                        win_ready;
   logic                        win_valid;
   logic [WINDOW*WINDOW*PB-1:0] win_taps;
   logic                        win_last;
   logic                        rank_ready;

   // Configuration writes; index 3 is not a register and is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rowf_pkg::WIDTH_RESET;
         height_ff <= rowf_pkg::HEIGHT_RESET;
         mode_ff   <= rowf_pkg::MODE_MEDIAN;
      end else if (csr_we) begin
         unique case (csr_index)
            rowf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[rowf_pkg::WIDTH_REG_BITS-1:0];
            rowf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HB-1:0];
            rowf_pkg::CSR_FILTER_MODE:  mode_ff   <= csr_wdata[rowf_pkg::MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry to what the line store and counters can hold.
   always_comb begin
      w_raw = EW'(width_ff);
      if (w_raw == '0) begin
         w_eff = WW'(1);
      end else if (w_raw > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_raw);
      end
      if (height_ff == '0) begin
         h_eff = HB'(1);
      end else if (height_ff > rowf_pkg::MAX_HEIGHT) begin
         h_eff = rowf_pkg::MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
      lag_in = TB'(w_eff) * TB'(PAD) + TB'(PAD);
   end

   // Frame length including the trailing filler, registered from the lag and product registers.
   always_ff @(posedge clock) begin
      lag_ff   <= lag_in;
      prod_ff  <= TB'(w_eff) * TB'(h_eff);
      total_ff <= prod_ff + lag_ff;
   end

   // Hold off req transfers until lag and frame length reflect the latest write.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '1;
      end else begin
         settle_ff <= {settle_ff[0], csr_we};
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign n_next     = TB'(n_ff) + TB'(1);
   assign frame_end  = n_next >= total_ff;
   assign has_out    = TB'(n_ff) >= lag_ff;
   assign col_wrap   = ({1'b0, col_ff} + WW'(1)) == w_eff;
   assign ocol_wrap  = ({1'b0, ocol_ff} + WW'(1)) == w_eff;

   always_comb begin
      s1_info_in.has_out = has_out;
      s1_info_in.last    = frame_end;
      s1_info_in.row     = orow_ff;
      s1_info_in.col     = PSB'(ocol_ff);
   end

   // Advance the raster counters on each transfer; clear them when the frame closes.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         col_ff  <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else if (accept) begin
         if (frame_end) begin
            n_ff    <= '0;
            col_ff  <= '0;
            orow_ff <= '0;
            ocol_ff <= '0;
         end else begin
            n_ff   <= n_next[NB-1:0];
            col_ff <= col_wrap ? '0 : col_ff + CW'(1);
            if (has_out) begin
               if (ocol_wrap) begin
                  ocol_ff <= '0;
                  orow_ff <= orow_ff + PSB'(1);
               end else begin
                  ocol_ff <= ocol_ff + CW'(1);
               end
            end
         end
      end
   end

   // Warm-up items still update the line store and window,
   // but drop out before the masking stage.
   assign s1_fire    = s1_v_ff && (!s1_info_ff.has_out || win_ready);
   assign req_tready = (settle_ff == '0) && (!s1_v_ff || s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_info_ff  <= s1_info_in;
      end
   end

   rowf_line_store #(
      .WINDOW    (WINDOW),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .pixel   (s1_pixel_ff),
      .col_vec (col_vec)
   );

   rowf_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_fire),
      .load_en   (s1_fire && s1_info_ff.has_out),
      .col_vec   (col_vec),
      .info      (s1_info_ff),
      .w_eff     (PSB'(w_eff)),
      .h_eff     (h_eff),
      .ready     (win_ready),
      .out_valid (win_valid),
      .out_ready (rank_ready),
      .out_taps  (win_taps),
      .out_last  (win_last)
   );

   rowf_rank_select #(
      .WINDOW (WINDOW)
   ) u_rank_select (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (win_valid),
      .in_ready  (rank_ready),
      .in_taps   (win_taps),
      .in_last   (win_last),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule
